// ===== hdl/aswc_pkg.sv =====
package aswc_pkg;

    // Channel count of one scan (default for the top-level parameter)
    localparam int CHANNEL_COUNT_DEF = 40;

    // Fixed field widths
    localparam int CHAN_W   = 6;
    localparam int SAMPLE_W = 8;
    localparam int WORD_W   = 40;
    localparam int THR_W    = 8;

    // Channel specials
    localparam logic [CHAN_W-1:0] FORCED_LOW_CH  = 6'd38;
    localparam logic [CHAN_W-1:0] FORCED_HIGH_CH = 6'd6;
    localparam logic [CHAN_W-1:0] ALT_LOW_FIRST  = 6'd28;
    localparam logic [CHAN_W-1:0] ALT_LOW_LAST   = 6'd31;
    localparam logic [CHAN_W-1:0] ALT_HIGH_A     = 6'd32;
    localparam logic [CHAN_W-1:0] ALT_HIGH_B     = 6'd33;
    localparam int KEY_SRC_BIT = 9;
    localparam int KEY_DST_BIT = 6;

    // Fixed floor of the low-only style
    localparam logic [THR_W-1:0] LOW_FLOOR = 8'd10;

    // Threshold reset values
    localparam logic [THR_W-1:0] LOW_THR_RST   = 8'd80;
    localparam logic [THR_W-1:0] HIGH_THR_RST  = 8'd170;
    localparam logic [THR_W-1:0] FLOOR_THR_RST = 8'd10;

    // Style codes
    typedef enum logic [1:0] {
        STYLE_LOW_ONLY  = 2'd0,
        STYLE_HIGH_ONLY = 2'd1,
        STYLE_HIGH_LOW  = 2'd2,
        STYLE_NONE      = 2'd3
    } style_t;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_STYLE_LOW      = 3'd0,
        REG_STYLE_HIGH     = 3'd1,
        REG_POLARITY       = 3'd2,
        REG_LOW_THR        = 3'd3,
        REG_LOW_THR_ALT    = 3'd4,
        REG_HIGH_THR       = 3'd5,
        REG_HIGH_THR_ALT   = 3'd6,
        REG_FLOOR_THR      = 3'd7
    } reg_idx_t;

    // Configuration register set
    typedef struct packed {
        logic [63:0]       style_low;
        logic [15:0]       style_high;
        logic [WORD_W-1:0] polarity_map;
        logic [THR_W-1:0]  low_thr;
        logic [THR_W-1:0]  low_thr_alt;
        logic [THR_W-1:0]  high_thr;
        logic [THR_W-1:0]  high_thr_alt;
        logic [THR_W-1:0]  floor_thr;
    } cfg_t;

    // Classifier decision for one sample
    typedef struct packed {
        logic hit;   // channel in range and style is not none
        logic value; // new scan bit
    } cls_t;

endpackage

// ===== hdl/aswc_classify.sv =====
module aswc_classify
    import aswc_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
)
(
    input  logic [CHAN_W-1:0]   channel,
    input  logic [SAMPLE_W-1:0] sample,
    input  cfg_t                cfg,
    output cls_t                cls
);

    localparam logic [CHAN_W:0] COUNT_LIM = (CHAN_W+1)'(CHANNEL_COUNT);

    logic [79:0]      style_all;
    logic [79:0]      style_shift;
    logic [WORD_W-1:0] pol_shift;
    style_t           style;
    logic             in_range;
    logic             alt_low;
    logic             alt_high;
    logic [THR_W-1:0] low_thr;
    logic [THR_W-1:0] high_thr;
    logic             pol;
    logic             above_floor;

    // Look up the channel's style, applying the forced channels
    always_comb
    begin
        style_all   = {cfg.style_high, cfg.style_low};
        style_shift = style_all >> {channel, 1'b0};
        if (channel == FORCED_LOW_CH)
            style = STYLE_LOW_ONLY;
        else if (channel == FORCED_HIGH_CH)
            style = STYLE_HIGH_ONLY;
        else
            style = style_t'(style_shift[1:0]);
    end

    // Select thresholds and polarity
    always_comb
    begin
        in_range    = {1'b0, channel} < COUNT_LIM;
        alt_low     = ((channel >= ALT_LOW_FIRST) && (channel <= ALT_LOW_LAST))
                      || (channel == FORCED_LOW_CH);
        alt_high    = (channel == ALT_HIGH_A) || (channel == ALT_HIGH_B);
        low_thr     = alt_low ? cfg.low_thr_alt : cfg.low_thr;
        high_thr    = alt_high ? cfg.high_thr_alt : cfg.high_thr;
        pol_shift   = cfg.polarity_map >> channel;
        pol         = pol_shift[0];
        above_floor = sample > cfg.floor_thr;
    end

    // Decide the scan bit
    always_comb
    begin
        cls.hit   = in_range;
        cls.value = 1'b0;
        case (style)
            STYLE_LOW_ONLY:
            begin
                cls.value = (sample < low_thr) && (sample > LOW_FLOOR);
            end
            STYLE_HIGH_ONLY:
            begin
                cls.value = sample > high_thr;
            end
            STYLE_HIGH_LOW:
            begin
                if ((sample > cfg.high_thr) && above_floor)
                    cls.value = pol;
                else if ((sample < cfg.low_thr) && above_floor)
                    cls.value = ~pol;
                else
                    cls.value = 1'b0;
            end
            default:
            begin
                cls.hit = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/analog_switch_input_classifier.sv =====
// Analog switch input classifier.
// Input stream: one ADC sample per request; s_tdata carries channel and sample,
// s_tlast marks the last channel of a scan. Each sample is classified by the
// channel's style and thresholds and written into the scan word.
// Output stream: one request per scan, issued for the sample marked s_tlast;
// m_tdata is the published switch word, m_tuser is the send flag (word updated).
// A sample is taken into the input register, classified and merged from there,
// and on a scan end its result is loaded into the output register when the input
// register advances; the output register drives m_tvalid.
// Throughput: one sample per cycle while no scan end is held; the classify and
// 40-bit compare path between the input register and the scan and output registers
// sets that figure. When the receiver stalls, the output register holds its result;
// samples keep flowing until a second scan end meets the full output register,
// which then holds that sample in the input register and drops s_tready.
// Reset clears the scan, stable and published words and loads the register
// defaults. Configuration is written over the APB port at byte address 8*i.
module analog_switch_input_classifier
    import aswc_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Sample stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [5:0] channel, [13:6] sample, [15:14] zero
    input  logic        s_tlast,  // scan_end
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // [39:0] published_word
    output logic        m_tuser,  // [0] send_event
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int CW = CHANNEL_COUNT;
    localparam logic [CW-1:0] KEY_SRC_MASK = CW'(1) << KEY_SRC_BIT;
    localparam logic [CW-1:0] KEY_DST_MASK = CW'(1) << KEY_DST_BIT;

    cfg_t                cfg_reg;
    reg_idx_t            reg_idx;

    logic                in_valid_reg;
    logic [CHAN_W-1:0]   chan_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                last_reg;

    logic [CW-1:0]       scan_reg;
    logic [CW-1:0]       scan_next;
    logic [CW-1:0]       stable_reg;
    logic [CW-1:0]       stable_next;
    logic [CW-1:0]       pub_reg;
    logic [CW-1:0]       pub_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [WORD_W-1:0]   out_word_reg;
    logic                out_send_reg;
    logic                send_next;

    cls_t                cls;
    logic [CW-1:0]       chan_mask;
    logic [CW-1:0]       scan_upd;
    logic                advance;
    logic                in_take;
    logic                cfg_wr;

    // Configuration write and read-back
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[5:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.style_low    <= '0;
            cfg_reg.style_high   <= '0;
            cfg_reg.polarity_map <= '0;
            cfg_reg.low_thr      <= LOW_THR_RST;
            cfg_reg.low_thr_alt  <= LOW_THR_RST;
            cfg_reg.high_thr     <= HIGH_THR_RST;
            cfg_reg.high_thr_alt <= HIGH_THR_RST;
            cfg_reg.floor_thr    <= FLOOR_THR_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_STYLE_LOW:    cfg_reg.style_low    <= pwdata;
                REG_STYLE_HIGH:   cfg_reg.style_high   <= pwdata[15:0];
                REG_POLARITY:     cfg_reg.polarity_map <= pwdata[WORD_W-1:0];
                REG_LOW_THR:      cfg_reg.low_thr      <= pwdata[THR_W-1:0];
                REG_LOW_THR_ALT:  cfg_reg.low_thr_alt  <= pwdata[THR_W-1:0];
                REG_HIGH_THR:     cfg_reg.high_thr     <= pwdata[THR_W-1:0];
                REG_HIGH_THR_ALT: cfg_reg.high_thr_alt <= pwdata[THR_W-1:0];
                REG_FLOOR_THR:    cfg_reg.floor_thr    <= pwdata[THR_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_STYLE_LOW:    prdata = cfg_reg.style_low;
            REG_STYLE_HIGH:   prdata = 64'(cfg_reg.style_high);
            REG_POLARITY:     prdata = 64'(cfg_reg.polarity_map);
            REG_LOW_THR:      prdata = 64'(cfg_reg.low_thr);
            REG_LOW_THR_ALT:  prdata = 64'(cfg_reg.low_thr_alt);
            REG_HIGH_THR:     prdata = 64'(cfg_reg.high_thr);
            REG_HIGH_THR_ALT: prdata = 64'(cfg_reg.high_thr_alt);
            REG_FLOOR_THR:    prdata = 64'(cfg_reg.floor_thr);
            default:          prdata = '0;
        endcase
    end

    // Hold a scan end in the input register only while the result slot is full
    assign advance  = in_valid_reg && (!last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take || advance)
            in_valid_reg <= in_take;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            chan_reg   <= s_tdata[CHAN_W-1:0];
            sample_reg <= s_tdata[CHAN_W+SAMPLE_W-1:CHAN_W];
            last_reg   <= s_tlast;
        end
    end

    aswc_classify #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_classify (
        .channel (chan_reg),
        .sample  (sample_reg),
        .cfg     (cfg_reg),
        .cls     (cls)
    );

    // Merge the bit and close the scan
    always_comb
    begin
        chan_mask   = CW'(1) << chan_reg;
        scan_upd    = scan_reg;
        if (cls.hit)
            scan_upd = (scan_reg & ~chan_mask) | (cls.value ? chan_mask : '0);
        scan_next   = scan_upd;
        stable_next = stable_reg;
        pub_next    = pub_reg;
        send_next   = 1'b0;
        if (last_reg)
        begin
            if (scan_upd != stable_reg)
            begin
                stable_next = scan_upd;
            end
            else if (pub_reg != stable_reg)
            begin
                if ((scan_upd & KEY_SRC_MASK) != '0)
                    scan_next = scan_upd | KEY_DST_MASK;
                pub_next  = scan_next;
                send_next = 1'b1;
            end
            if ((scan_next & KEY_SRC_MASK) != '0)
                pub_next = pub_next | KEY_DST_MASK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg   <= '0;
            stable_reg <= '0;
            pub_reg    <= '0;
        end
        else if (advance)
        begin
            scan_reg   <= scan_next;
            stable_reg <= stable_next;
            pub_reg    <= pub_next;
        end
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        if (advance && last_reg)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
        begin
            out_word_reg <= WORD_W'(pub_next);
            out_send_reg <= send_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tuser  = out_send_reg;

endmodule

// ===== tb/sv/switch_scan_checker.sv =====
`timescale 1ns / 100ps

module switch_scan_checker
    import aswc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [15:0]       s_tdata,   // [5:0] channel, [13:6] sample, [15:14] zero
    input  logic              s_tlast,   // scan_end
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [WORD_W-1:0] m_tdata,   // [39:0] published_word
    input  logic              m_tuser,   // [0] send_event
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [5:0]        paddr,
    input  logic [63:0]       pwdata,
    input  logic              pready,
    output int                mismatch_count,
    output int                words_pending,
    output int                results_checked,
    output int                updates_seen
);

    localparam int LOW_BANK   = 32;  // channels held in style_low
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              send;
    } scan_result_t;

    cfg_t              cfg;
    logic [WORD_W-1:0] scan_word;
    logic [WORD_W-1:0] stable_word;
    logic [WORD_W-1:0] pub_word;
    scan_result_t      expected_results[$];

    // Decide the scan bit of one sample under the current register set
    function automatic cls_t classify_sample(input logic [CHAN_W-1:0]   ch,
                                             input logic [SAMPLE_W-1:0] smp);
        cls_t            r;
        style_t          sty;
        logic            pol;
        logic [THR_W-1:0] thr;
        r = '0;
        if (ch >= CHANNEL_COUNT_DEF)
            return r;
        if (ch == FORCED_LOW_CH)
            sty = STYLE_LOW_ONLY;
        else if (ch == FORCED_HIGH_CH)
            sty = STYLE_HIGH_ONLY;
        else if (ch < LOW_BANK)
            sty = style_t'(cfg.style_low[2*ch +: 2]);
        else
            sty = style_t'(cfg.style_high[2*(ch - LOW_BANK) +: 2]);
        pol = cfg.polarity_map[ch];
        case (sty)
            STYLE_LOW_ONLY:
            begin
                thr = ((ch >= ALT_LOW_FIRST && ch <= ALT_LOW_LAST) || ch == FORCED_LOW_CH)
                      ? cfg.low_thr_alt : cfg.low_thr;
                r.hit   = 1'b1;
                r.value = (smp < thr) && (smp > LOW_FLOOR);
            end
            STYLE_HIGH_ONLY:
            begin
                thr = (ch == ALT_HIGH_A || ch == ALT_HIGH_B) ? cfg.high_thr_alt : cfg.high_thr;
                r.hit   = 1'b1;
                r.value = (smp > thr);
            end
            STYLE_HIGH_LOW:
            begin
                r.hit = 1'b1;
                if (smp > cfg.high_thr && smp > cfg.floor_thr)
                    r.value = pol;
                else if (smp < cfg.low_thr && smp > cfg.floor_thr)
                    r.value = ~pol;
                else
                    r.value = 1'b0;
            end
            default:
                r.hit = 1'b0;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        scan_result_t  got;
        scan_result_t  exp_res;
        scan_result_t  nxt;
        cls_t          cls;
        logic [CHAN_W-1:0]   ch;
        logic [SAMPLE_W-1:0] smp;
        if (!rst_n)
        begin
            cfg.style_low    = '0;
            cfg.style_high   = '0;
            cfg.polarity_map = '0;
            cfg.low_thr      = LOW_THR_RST;
            cfg.low_thr_alt  = LOW_THR_RST;
            cfg.high_thr     = HIGH_THR_RST;
            cfg.high_thr_alt = HIGH_THR_RST;
            cfg.floor_thr    = FLOOR_THR_RST;
            scan_word        = '0;
            stable_word      = '0;
            pub_word         = '0;
            expected_results.delete();
            mismatch_count   = 0;
            results_checked  = 0;
            updates_seen     = 0;
        end
        else
        begin
            // Track register writes
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[5:3]))
                    REG_STYLE_LOW:    cfg.style_low    = pwdata;
                    REG_STYLE_HIGH:   cfg.style_high   = pwdata[15:0];
                    REG_POLARITY:     cfg.polarity_map = pwdata[WORD_W-1:0];
                    REG_LOW_THR:      cfg.low_thr      = pwdata[THR_W-1:0];
                    REG_LOW_THR_ALT:  cfg.low_thr_alt  = pwdata[THR_W-1:0];
                    REG_HIGH_THR:     cfg.high_thr     = pwdata[THR_W-1:0];
                    REG_HIGH_THR_ALT: cfg.high_thr_alt = pwdata[THR_W-1:0];
                    REG_FLOOR_THR:    cfg.floor_thr    = pwdata[THR_W-1:0];
                    default:          ;
                endcase
            end

            // Check a result request against the oldest expected word
            if (m_tvalid && m_tready)
            begin
                got.word = m_tdata;
                got.send = m_tuser;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("[%0t] unexpected result: word %h send %b",
                                 $realtime, got.word, got.send);
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    results_checked++;
                    if (exp_res.send)
                        updates_seen++;
                    if (got.word !== exp_res.word || got.send !== exp_res.send)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("[%0t] scan result %0d: word exp %h got %h, send exp %b got %b",
                                     $realtime, results_checked, exp_res.word, got.word,
                                     exp_res.send, got.send);
                    end
                end
            end

            // Classify an accepted sample and close the scan on its last one
            if (s_tvalid && s_tready)
            begin
                ch  = s_tdata[CHAN_W-1:0];
                smp = s_tdata[CHAN_W +: SAMPLE_W];
                cls = classify_sample(ch, smp);
                if (cls.hit)
                    scan_word[ch] = cls.value;
                if (s_tlast)
                begin
                    nxt.send = 1'b0;
                    if (scan_word != stable_word)
                        stable_word = scan_word;
                    else if (pub_word != stable_word)
                    begin
                        if (scan_word[KEY_SRC_BIT])
                            scan_word[KEY_DST_BIT] = 1'b1;
                        pub_word = scan_word;
                        nxt.send = 1'b1;
                    end
                    if (scan_word[KEY_SRC_BIT])
                        pub_word[KEY_DST_BIT] = 1'b1;
                    nxt.word = pub_word;
                    expected_results.push_back(nxt);
                end
            end
        end
        words_pending = expected_results.size();
    end

endmodule

// ===== tb/sv/tb_analog_switch_input_classifier.sv =====
`timescale 1ns / 100ps

module tb_analog_switch_input_classifier;
    import aswc_pkg::*;

    localparam int HALF_PERIOD        = 4;
    localparam int DRAIN_CYCLES       = 4;     // block latency plus margin
    localparam int HOLD_CYCLES        = 300;   // long receiver hold-off
    localparam int QUIET_LIMIT        = 2000;  // cycles with no request moved
    localparam int RANDOM_PER_SETTING = 92;
    localparam int MAX_SCAN_LEN       = 12;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [15:0]       s_tdata;   // [5:0] channel, [13:6] sample, [15:14] zero
    logic              s_tlast;   // scan_end
    logic              m_tvalid;
    logic              m_tready;
    logic [WORD_W-1:0] m_tdata;   // [39:0] published_word
    logic              m_tuser;   // [0] send_event
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [5:0]        paddr;
    logic [63:0]       pwdata;
    logic [63:0]       prdata;
    logic              pready;

    int mismatch_count;
    int words_pending;
    int results_checked;
    int updates_seen;

    int tx_idle_pct;
    int rx_idle_pct;
    int items_sent;
    int quiet_cycles;
    int hold_req;

    analog_switch_input_classifier dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    switch_scan_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatch_count  (mismatch_count),
        .words_pending   (words_pending),
        .results_checked (results_checked),
        .updates_seen    (updates_seen)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Abort when no request moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no request moved for %0d cycles", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Drive the result ready: random stalls, or a long hold when asked
    initial
    begin
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != holds_done)
            begin
                hold_left  = HOLD_CYCLES;
                holds_done = hold_req;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return SAMPLE_W'($urandom_range(9, 12));
            default: return SAMPLE_W'($urandom_range(255));
        endcase
    endfunction

    // Offer one sample and hold it until the request is taken
    task automatic drive_sample(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] smp,
                                input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, smp, ch};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // Stop offering and let every expected result drain
    task automatic settle_block();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (words_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Load one full register set once the block is idle
    task automatic load_setting(input int k);
        logic [63:0]       sl;
        logic [15:0]       sh;
        logic [WORD_W-1:0] pol;
        logic [THR_W-1:0]  lo;
        logic [THR_W-1:0]  lo_alt;
        logic [THR_W-1:0]  hi;
        logic [THR_W-1:0]  hi_alt;
        logic [THR_W-1:0]  flr;
        case (k)
            0:
            begin
                // style_low cycles low-only, high-only, high-or-low, none
                sl = 64'hE4E4_E4E4_E4E4_E4E4;
                sh = 16'hE495;
                pol = 40'hA5_5A5A_A5A5;
                lo = 8'd80;  lo_alt = 8'd60;  hi = 8'd170;  hi_alt = 8'd200;  flr = 8'd30;
            end
            1:
            begin
                sl = '0;  sh = '0;  pol = '0;
                lo = '0;  lo_alt = '0;  hi = '0;  hi_alt = '0;  flr = '0;
            end
            2:
            begin
                sl = '1;  sh = '1;  pol = '1;
                lo = '1;  lo_alt = '1;  hi = '1;  hi_alt = '1;  flr = '1;
            end
            3:
            begin
                sl     = 64'hAAAA_AAAA_AAAA_AAAA;
                sh     = 16'hAAAA;
                pol    = WORD_W'({$urandom, $urandom});
                lo     = THR_W'($urandom_range(40, 120));
                lo_alt = THR_W'($urandom_range(40, 120));
                hi     = THR_W'($urandom_range(130, 220));
                hi_alt = THR_W'($urandom_range(130, 220));
                flr    = THR_W'($urandom_range(0, 40));
            end
            default:
            begin
                sl     = {$urandom, $urandom};
                sh     = 16'($urandom);
                pol    = WORD_W'({$urandom, $urandom});
                lo     = THR_W'($urandom_range(255));
                lo_alt = THR_W'($urandom_range(255));
                hi     = THR_W'($urandom_range(255));
                hi_alt = THR_W'($urandom_range(255));
                flr    = THR_W'($urandom_range(255));
            end
        endcase
        settle_block();
        write_reg(REG_STYLE_LOW, sl);
        write_reg(REG_STYLE_HIGH, 64'(sh));
        write_reg(REG_POLARITY, 64'(pol));
        write_reg(REG_LOW_THR, 64'(lo));
        write_reg(REG_LOW_THR_ALT, 64'(lo_alt));
        write_reg(REG_HIGH_THR, 64'(hi));
        write_reg(REG_HIGH_THR_ALT, 64'(hi_alt));
        write_reg(REG_FLOOR_THR, 64'(flr));
    endtask

    // Same scan three times: forced channels, alternate thresholds, key bit,
    // a none-style channel and an out-of-range channel closing the scan
    task automatic run_directed();
        repeat (3)
        begin
            drive_sample(6'd0, 8'd255, 1'b0);
            drive_sample(6'd3, 8'd100, 1'b0);
            drive_sample(FORCED_HIGH_CH, 8'd255, 1'b0);
            drive_sample(CHAN_W'(KEY_SRC_BIT), 8'd255, 1'b0);
            drive_sample(ALT_LOW_FIRST, 8'd50, 1'b0);
            drive_sample(ALT_HIGH_A, 8'd201, 1'b0);
            drive_sample(FORCED_LOW_CH, 8'd11, 1'b0);
            drive_sample(6'd63, 8'd0, 1'b1);
        end
    endtask

    // Random scans, mostly repeated so the word settles and gets published
    task automatic run_scan_groups(input int n_items);
        logic [CHAN_W-1:0]   chs  [MAX_SCAN_LEN];
        logic [SAMPLE_W-1:0] smps [MAX_SCAN_LEN];
        int len;
        int reps;
        int done;
        done = 0;
        while (done < n_items)
        begin
            len = $urandom_range(1, MAX_SCAN_LEN);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(99) < 8)
                    chs[i] = CHAN_W'($urandom_range(CHANNEL_COUNT_DEF, 63));
                else
                    chs[i] = CHAN_W'($urandom_range(CHANNEL_COUNT_DEF - 1));
                smps[i] = pick_sample();
            end
            reps = $urandom_range(1, 3);
            for (int r = 0; r < reps; r++)
            begin
                // occasionally disturb a repeat so the scans disagree
                if (r > 0 && $urandom_range(99) < 12)
                    smps[$urandom_range(len - 1)] = pick_sample();
                for (int i = 0; i < len; i++)
                    drive_sample(chs[i], smps[i], i == len - 1);
                done += len;
            end
        end
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        items_sent  = 0;
        hold_req    = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Sender idles less than the receiver
        tx_idle_pct = 26;
        rx_idle_pct = 57;
        load_setting(0);
        run_directed();
        run_scan_groups(RANDOM_PER_SETTING);
        load_setting(3);
        run_scan_groups(RANDOM_PER_SETTING);

        // Receiver idles less than the sender
        settle_block();
        tx_idle_pct = 57;
        rx_idle_pct = 26;
        load_setting(1);
        run_scan_groups(RANDOM_PER_SETTING);
        load_setting(4);
        run_scan_groups(RANDOM_PER_SETTING);

        // No idling; hold results off long enough to back up the input
        settle_block();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_setting(2);
        hold_req++;
        run_scan_groups(RANDOM_PER_SETTING);
        load_setting(5);
        run_scan_groups(RANDOM_PER_SETTING);

        settle_block();
        $display("%0d samples sent over six register settings and three idling mixes, "
                 , items_sent, "including a long hold on the result side");
        $display("%0d scan results checked, %0d of them carried a word update",
                 results_checked, updates_seen);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
